// ----- src/bss_pkg.sv -----
package bss_pkg;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_READ_TOTAL = 2'd1,
    OP_READ_ENTRY = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_DROPPED = 2'd1,
    ST_BAD_SELECT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    TBL_BYTE = 2'd0,
    TBL_ALL = 2'd1,
    TBL_EVEN = 2'd2,
    TBL_ODD = 2'd3
  } table_t;

  typedef enum logic [3:0] {
    TOT_COUNT = 4'd0,
    TOT_ONES = 4'd1,
    TOT_SUM = 4'd2,
    TOT_SQUARES = 4'd3,
    TOT_DIFFS = 4'd4,
    TOT_RUN = 4'd5,
    TOT_LOW = 4'd6,
    TOT_MID = 4'd7,
    TOT_HIGH = 4'd8
  } total_t;

  typedef enum logic [1:0] {
    CFG_BIGRAM = 2'd0,
    CFG_LOW = 2'd1,
    CFG_HIGH = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_WRITE,
    BK_CLEAR,
    BK_RESULT
  } bk_state_t;

  localparam int unsigned READ_WIDTH = 48;
  localparam int unsigned PAIR_AW = 16;
  localparam int unsigned BYTE_AW = 8;

  typedef struct packed {
    op_t opcode;
    logic [7:0] data_byte;
    table_t table_select;
    logic [15:0] entry_index;
    logic [3:0] total_select;
  } cmd_t;

endpackage

// ----- src/bss_ram.sv -----
module bss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/bss_front.sv -----
module bss_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bss_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_pop,
  output bss_pkg::cmd_t q_cmd
);

  bss_pkg::cmd_t slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, rp_r;
  logic push;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (q_pop && q_valid) rp_r <= !rp_r;
    end
    if (push) slot_r[wp_r] <= in_cmd;
  end

endmodule

// ----- src/bss_back.sv -----
module bss_back #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  bss_pkg::cmd_t        q_cmd,
  input  logic [2:0]           bigram_enable,
  input  logic [7:0]           low_bound,
  input  logic [8:0]           high_bound,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [47:0]          out_read_value,
  output logic [1:0]           out_status
);

  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned OW = CW + 3;
  localparam int unsigned SW = CW + 8;
  localparam int unsigned QW = CW + 16;
  localparam logic [CW-1:0] CMAX = '1;

  bss_pkg::bk_state_t st_r, st_nxt;
  bss_pkg::cmd_t cmd_r;

  logic [CW-1:0] total_r, low_r, mid_r, high_r, longest_r, run_r;
  logic [OW-1:0] ones_r;
  logic [SW-1:0] sum_r, diff_r;
  logic [QW-1:0] sq_r;
  logic [7:0] last_r;

  logic [bss_pkg::PAIR_AW-1:0] clr_r;
  logic clr_done;
  logic init_r;

  logic [47:0] val_r;
  logic [1:0] stat_r;
  logic obuf_v_r;

  logic [CW-1:0] hb_rd, pa_rd, pe_rd, po_rd;
  logic [CW-1:0] hb_v, pa_v, pe_v, po_v;
  logic hb_we, pa_we, pe_we, po_we;
  logic [bss_pkg::BYTE_AW-1:0] hb_ra, hb_wa;
  logic [bss_pkg::PAIR_AW-1:0] pr_ra, pr_wa;
  logic [CW-1:0] hb_wd, pa_wd, pe_wd, po_wd;
  logic [bss_pkg::PAIR_AW-1:0] pair_r;
  logic first_r, even_r, full_r;

  logic [QW-1:0] sel_val;
  logic [47:0] sat_val;
  logic [1:0] sel_stat;
  logic [3:0] ones_cnt;
  logic [7:0] absd;
  logic [15:0] sqv;

  assign clr_done = (clr_r == '1);
  assign q_pop = (st_r == bss_pkg::BK_IDLE) && q_valid;
  assign out_valid = obuf_v_r;
  assign out_read_value = val_r;
  assign out_status = stat_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      bss_pkg::BK_IDLE: if (q_valid) st_nxt = bss_pkg::BK_READ;
      bss_pkg::BK_READ: begin
        if (cmd_r.opcode == bss_pkg::OP_CLEAR) st_nxt = bss_pkg::BK_CLEAR;
        else if (cmd_r.opcode == bss_pkg::OP_ACCUM) st_nxt = bss_pkg::BK_WRITE;
        else st_nxt = bss_pkg::BK_RESULT;
      end
      bss_pkg::BK_WRITE: st_nxt = bss_pkg::BK_RESULT;
      bss_pkg::BK_CLEAR: begin
        if (clr_done) st_nxt = init_r ? bss_pkg::BK_IDLE : bss_pkg::BK_RESULT;
      end
      bss_pkg::BK_RESULT: if (!obuf_v_r || !out_stall) st_nxt = bss_pkg::BK_IDLE;
      default: st_nxt = bss_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    ones_cnt = '0;
    for (int i = 0; i < 8; i++) ones_cnt = ones_cnt + {3'd0, cmd_r.data_byte[i]};
    absd = (cmd_r.data_byte >= last_r) ? cmd_r.data_byte - last_r
                                       : last_r - cmd_r.data_byte;
    sqv = {8'd0, cmd_r.data_byte} * {8'd0, cmd_r.data_byte};
  end

  assign hb_v = hb_rd;
  assign pa_v = pa_rd;
  assign pe_v = pe_rd;
  assign po_v = po_rd;

  always_comb begin
    hb_ra = (cmd_r.opcode == bss_pkg::OP_ACCUM) ? cmd_r.data_byte
                                               : cmd_r.entry_index[7:0];
    pr_ra = (cmd_r.opcode == bss_pkg::OP_ACCUM) ? {last_r, cmd_r.data_byte}
                                               : cmd_r.entry_index;
    if (st_r == bss_pkg::BK_IDLE) begin
      hb_ra = (q_cmd.opcode == bss_pkg::OP_ACCUM) ? q_cmd.data_byte
                                                 : q_cmd.entry_index[7:0];
      pr_ra = (q_cmd.opcode == bss_pkg::OP_ACCUM) ? {last_r, q_cmd.data_byte}
                                                 : q_cmd.entry_index;
    end
    hb_wa = cmd_r.data_byte;
    pr_wa = pair_r;
    hb_wd = hb_v + 1'b1;
    pa_wd = pa_v + 1'b1;
    pe_wd = pe_v + 1'b1;
    po_wd = po_v + 1'b1;
    hb_we = 1'b0;
    pa_we = 1'b0;
    pe_we = 1'b0;
    po_we = 1'b0;
    if (st_r == bss_pkg::BK_WRITE && !full_r) begin
      hb_we = 1'b1;
      pa_we = !first_r && bigram_enable[0];
      pe_we = !first_r && even_r && bigram_enable[1];
      po_we = !first_r && !even_r && bigram_enable[2];
    end
    if (st_r == bss_pkg::BK_CLEAR) begin
      hb_wa = clr_r[7:0];
      pr_wa = clr_r;
      hb_wd = '0;
      pa_wd = '0;
      pe_wd = '0;
      po_wd = '0;
      hb_we = (clr_r[15:8] == 8'd0);
      pa_we = 1'b1;
      pe_we = 1'b1;
      po_we = 1'b1;
    end
  end

  bss_ram #(.WIDTH(CW), .DEPTH(256)) u_hb (
    .clk(clk), .we(hb_we), .waddr(hb_wa), .wdata(hb_wd), .raddr(hb_ra), .rdata(hb_rd));
  bss_ram #(.WIDTH(CW), .DEPTH(65536)) u_pa (
    .clk(clk), .we(pa_we), .waddr(pr_wa), .wdata(pa_wd), .raddr(pr_ra), .rdata(pa_rd));
  bss_ram #(.WIDTH(CW), .DEPTH(65536)) u_pe (
    .clk(clk), .we(pe_we), .waddr(pr_wa), .wdata(pe_wd), .raddr(pr_ra), .rdata(pe_rd));
  bss_ram #(.WIDTH(CW), .DEPTH(65536)) u_po (
    .clk(clk), .we(po_we), .waddr(pr_wa), .wdata(po_wd), .raddr(pr_ra), .rdata(po_rd));

  always_comb begin
    sel_val = '0;
    sel_stat = bss_pkg::ST_OK;
    case (cmd_r.opcode)
      bss_pkg::OP_ACCUM: if (full_r) sel_stat = bss_pkg::ST_DROPPED;
      bss_pkg::OP_READ_TOTAL: begin
        case (cmd_r.total_select)
          bss_pkg::TOT_COUNT: sel_val = QW'(total_r);
          bss_pkg::TOT_ONES: sel_val = QW'(ones_r);
          bss_pkg::TOT_SUM: sel_val = QW'(sum_r);
          bss_pkg::TOT_SQUARES: sel_val = sq_r;
          bss_pkg::TOT_DIFFS: sel_val = QW'(diff_r);
          bss_pkg::TOT_RUN: sel_val = QW'(longest_r);
          bss_pkg::TOT_LOW: sel_val = QW'(low_r);
          bss_pkg::TOT_MID: sel_val = QW'(mid_r);
          bss_pkg::TOT_HIGH: sel_val = QW'(high_r);
          default: sel_stat = bss_pkg::ST_BAD_SELECT;
        endcase
      end
      bss_pkg::OP_READ_ENTRY: begin
        case (cmd_r.table_select)
          bss_pkg::TBL_BYTE: sel_val = QW'(hb_v);
          bss_pkg::TBL_ALL: sel_val = QW'(pa_v);
          bss_pkg::TBL_EVEN: sel_val = QW'(pe_v);
          default: sel_val = QW'(po_v);
        endcase
      end
      default: sel_val = '0;
    endcase
    sat_val = ((sel_val >> 48) != '0) ? 48'hFFFF_FFFF_FFFF : 48'(sel_val);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bss_pkg::BK_CLEAR;
      init_r <= 1'b1;
      obuf_v_r <= 1'b0;
      clr_r <= '0;
      total_r <= '0; low_r <= '0; mid_r <= '0; high_r <= '0;
      longest_r <= '0; run_r <= '0; ones_r <= '0; sum_r <= '0;
      diff_r <= '0; sq_r <= '0; last_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == bss_pkg::BK_RESULT && st_nxt == bss_pkg::BK_IDLE) obuf_v_r <= 1'b1;
      else if (obuf_v_r && !out_stall) obuf_v_r <= 1'b0;
      if (st_r == bss_pkg::BK_IDLE && q_valid) cmd_r <= q_cmd;
      if (st_r == bss_pkg::BK_READ) begin
        pair_r <= {last_r, cmd_r.data_byte};
        first_r <= (total_r == '0);
        even_r <= !total_r[0];
        full_r <= (total_r == CMAX);
      end
      if (st_r == bss_pkg::BK_WRITE && !full_r) begin
        if (cmd_r.data_byte < low_bound) low_r <= low_r + 1'b1;
        else if ({1'b0, cmd_r.data_byte} < high_bound) mid_r <= mid_r + 1'b1;
        else high_r <= high_r + 1'b1;
        ones_r <= ones_r + OW'(ones_cnt);
        sum_r <= sum_r + SW'(cmd_r.data_byte);
        sq_r <= sq_r + QW'(sqv);
        if (!first_r) begin
          diff_r <= diff_r + SW'(absd);
          if (cmd_r.data_byte == last_r) begin
            run_r <= run_r + 1'b1;
            if (run_r + 1'b1 > longest_r) longest_r <= run_r + 1'b1;
          end else begin
            run_r <= CW'(1);
          end
        end else begin
          run_r <= CW'(1);
        end
        last_r <= cmd_r.data_byte;
        total_r <= total_r + 1'b1;
      end
      if (st_r == bss_pkg::BK_CLEAR) begin
        clr_r <= clr_r + 1'b1;
        if (clr_done) init_r <= 1'b0;
        total_r <= '0; low_r <= '0; mid_r <= '0; high_r <= '0;
        longest_r <= '0; run_r <= '0; ones_r <= '0; sum_r <= '0;
        diff_r <= '0; sq_r <= '0; last_r <= '0;
      end
      if (st_r == bss_pkg::BK_RESULT && st_nxt == bss_pkg::BK_IDLE) begin
        val_r <= sat_val;
        stat_r <= sel_stat;
      end
    end
  end

endmodule

// ----- src/byte_stream_statistics_unit.sv -----
// Byte stream statistics unit. Commands enter through a two-word queue and
// run one at a time in the back end. An accumulate does one read-modify-write
// over the histogram RAMs; reads do not write them. Clear walks every pair RAM
// address. The same walk runs once after reset before the first command is
// taken, so every table reads zero until written. Totals are in flip-flops.
module byte_stream_statistics_unit #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_data_byte,
  input  logic [1:0]  in_table_select,
  input  logic [15:0] in_entry_index,
  input  logic [3:0]  in_total_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_read_value,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  bss_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;
  logic [2:0] bigram_r;
  logic [7:0] low_r;
  logic [8:0] high_r;

  assign cfg_ready = 1'b1;
  assign in_cmd = '{opcode: bss_pkg::op_t'(in_opcode), data_byte: in_data_byte,
                    table_select: bss_pkg::table_t'(in_table_select),
                    entry_index: in_entry_index, total_select: in_total_select};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bigram_r <= 3'd7;
      low_r <= 8'd32;
      high_r <= 9'd128;
    end else if (cfg_valid) begin
      case (bss_pkg::cfg_reg_t'(cfg_index))
        bss_pkg::CFG_BIGRAM: bigram_r <= cfg_data[2:0];
        bss_pkg::CFG_LOW: low_r <= cfg_data[7:0];
        bss_pkg::CFG_HIGH: high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  bss_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd));

  bss_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .bigram_enable(bigram_r), .low_bound(low_r), .high_bound(high_r),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_read_value(out_read_value), .out_status(out_status));

endmodule

// ----- src/bss_checker.sv -----
module bss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [47:0] out_read_value,
  input logic [1:0]  out_status
);

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bss_pkg::ST_OK |-> out_read_value == 48'd0)
    else $error("nonzero value with error");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value))
    else $error("result changed under stall");

endmodule

bind byte_stream_statistics_unit bss_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_read_value(out_read_value), .out_status(out_status));
